### rtl/h3t2_pkg.sv
// Shared types, constants and key table of the Hangul three-set to two-set converter.
package h3t2_pkg;

  localparam int unsigned NumKeys      = 39;
  localparam int unsigned NumLayerKeys = 5;
  localparam int unsigned FlagW        = 10;
  localparam int unsigned SlotW        = 3;

  localparam logic [15:0] TapTimeoutRst = 16'd300;

  // compose flag positions and groups
  localparam int unsigned FCho      = 0;
  localparam int unsigned FTieut    = 6;
  localparam int unsigned FJo       = 7;
  localparam int unsigned FJeu      = 8;
  localparam int unsigned FJu       = 9;
  localparam logic [FlagW-1:0] ChoBit   = 10'(1) << FCho;
  localparam logic [FlagW-1:0] DblMask  = 10'h03E;
  localparam logic [FlagW-1:0] JungMask = 10'h380;

  // HID usage of backspace, tapped ahead of a doubled consonant
  localparam logic [8:0] HidBspc = 9'h02A;

  typedef enum logic [1:0] {
    ACT_TAP       = 2'd0,
    ACT_LAYER_ON  = 2'd1,
    ACT_LAYER_OFF = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    K_DBL   = 3'd0,
    K_INIT  = 3'd1,
    K_DUAL  = 3'd2,
    K_CMB   = 3'd3,
    K_VOW   = 3'd4,
    K_D     = 3'd5,
    K_PLAIN = 3'd6,
    K_LAYER = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] a;
    logic [3:0] b;
    logic [8:0] first;   // bit 8 is left shift
    logic [8:0] second;
  } key_entry_t;

  typedef struct packed {
    action_e    action;
    logic [7:0] code;
    logic       shift;
    logic [1:0] layer;
    logic       last;
  } res_t;

  // results of one accepted request, handed to the output queue
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic key_entry_t ke(kind_e kind, logic [3:0] a, logic [3:0] b,
                                    logic [8:0] first, logic [8:0] second);
    key_entry_t e;
    e.kind   = kind;
    e.a      = a;
    e.b      = b;
    e.first  = first;
    e.second = second;
    return e;
  endfunction

  function automatic key_entry_t key_lookup(logic [5:0] key);
    key_entry_t e;
    case (key)
      6'd0:    e = ke(K_DBL,   4'd1, 4'd0, 9'h015, 9'h115);
      6'd1:    e = ke(K_INIT,  4'd0, 4'd0, 9'h016, 9'h000);
      6'd2:    e = ke(K_DBL,   4'd2, 4'd0, 9'h008, 9'h108);
      6'd3:    e = ke(K_INIT,  4'd0, 4'd0, 9'h009, 9'h000);
      6'd4:    e = ke(K_DUAL,  4'(FJeu), 4'(FJo), 9'h010, 9'h004);
      6'd5:    e = ke(K_DBL,   4'd3, 4'd0, 9'h014, 9'h114);
      6'd6:    e = ke(K_DBL,   4'd4, 4'd0, 9'h017, 9'h117);
      6'd7:    e = ke(K_INIT,  4'd0, 4'd0, 9'h007, 9'h000);
      6'd8:    e = ke(K_DBL,   4'd5, 4'd0, 9'h01A, 9'h11A);
      6'd9:    e = ke(K_DUAL,  4'(FJu), 4'(FJu), 9'h011, 9'h006);
      6'd10:   e = ke(K_DUAL,  4'(FJo), 4'(FJo), 9'h00B, 9'h01D);
      6'd11:   e = ke(K_INIT,  4'd0, 4'd0, 9'h01B, 9'h000);
      6'd12:   e = ke(K_DBL,   4'(FTieut), 4'd0, 9'h036, 9'h01B);
      6'd13:   e = ke(K_INIT,  4'd0, 4'd0, 9'h019, 9'h000);
      6'd14:   e = ke(K_INIT,  4'd0, 4'd0, 9'h00A, 9'h000);
      6'd15:   e = ke(K_CMB,   4'(FJo), 4'd0, 9'h00E, 9'h019);
      6'd16:   e = ke(K_CMB,   4'(FJo), 4'd0, 9'h012, 9'h014);
      6'd17:   e = ke(K_VOW,   4'd0, 4'd0, 9'h00C, 9'h009);
      6'd18:   e = ke(K_VOW,   4'd0, 4'd0, 9'h112, 9'h017);
      6'd19:   e = ke(K_CMB,   4'(FJu), 4'd0, 9'h00D, 9'h01B);
      6'd20:   e = ke(K_CMB,   4'(FJu), 4'd0, 9'h013, 9'h015);
      6'd21:   e = ke(K_VOW,   4'd0, 4'd0, 9'h018, 9'h01D);
      6'd22:   e = ke(K_VOW,   4'd0, 4'd0, 9'h113, 9'h016);
      6'd23:   e = ke(K_VOW,   4'd0, 4'd0, 9'h00B, 9'h01A);
      6'd24:   e = ke(K_VOW,   4'd0, 4'd0, 9'h01C, 9'h117);
      6'd25:   e = ke(K_VOW,   4'd0, 4'd0, 9'h011, 9'h006);
      6'd26:   e = ke(K_VOW,   4'd0, 4'd0, 9'h005, 9'h007);
      6'd27:   e = ke(K_VOW,   4'd0, 4'd0, 9'h010, 9'h008);
      6'd28:   e = ke(K_D,     4'd0, 4'd0, 9'h00F, 9'h00A);
      6'd29:   e = ke(K_VOW,   4'd0, 4'd0, 9'h004, 9'h004);
      6'd30:   e = ke(K_PLAIN, 4'd0, 4'd0, 9'h029, 9'h000);
      6'd31:   e = ke(K_LAYER, 4'd0, 4'd0, 9'h02A, 9'h000);
      6'd32:   e = ke(K_LAYER, 4'd1, 4'd0, 9'h02C, 9'h000);
      6'd33:   e = ke(K_LAYER, 4'd2, 4'd1, 9'h02C, 9'h000);
      6'd34:   e = ke(K_LAYER, 4'd3, 4'd2, 9'h02C, 9'h000);
      6'd35:   e = ke(K_LAYER, 4'd4, 4'd3, 9'h02C, 9'h000);
      6'd36:   e = ke(K_PLAIN, 4'd0, 4'd0, 9'h02C, 9'h000);
      6'd37:   e = ke(K_PLAIN, 4'd0, 4'd0, 9'h02A, 9'h000);
      6'd38:   e = ke(K_PLAIN, 4'd0, 4'd0, 9'h028, 9'h000);
      default: e = ke(K_PLAIN, 4'd0, 4'd0, 9'h000, 9'h000);
    endcase
    return e;
  endfunction

  function automatic res_t mk_tap(logic [8:0] code);
    res_t r;
    r.action = ACT_TAP;
    r.code   = code[7:0];
    r.shift  = code[8];
    r.layer  = 2'd0;
    r.last   = 1'b0;
    return r;
  endfunction

  function automatic res_t mk_layer(action_e act, logic [1:0] layer);
    res_t r;
    r.action = act;
    r.code   = 8'd0;
    r.shift  = 1'b0;
    r.layer  = layer;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

### rtl/h3t2_if.sv
// Valid/ready channel interfaces for key events and output actions.
interface h3t2_in_if;
  logic        valid;
  logic        ready;
  logic [5:0]  key;
  logic        pressed;
  logic [15:0] now_ms;

  modport source (output valid, output key, output pressed, output now_ms, input ready);
  modport sink   (input valid, input key, input pressed, input now_ms, output ready);
endinterface

interface h3t2_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] code;
  logic       shift;
  logic [1:0] layer;
  logic       last;

  modport source (output valid, output action, output code, output shift, output layer,
                  output last, input ready);
  modport sink   (input valid, input action, input code, input shift, input layer,
                  input last, output ready);
endinterface

### rtl/h3t2_ctrl.sv
// Compose flags, layer-key hold times and per-event result generation.
module h3t2_ctrl import h3t2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        acc_i,
  input  logic [5:0]  key_i,
  input  logic        pressed_i,
  input  logic [15:0] now_ms_i,
  input  logic [15:0] timeout_i,
  output push_t       push_o
);

  logic [FlagW-1:0] flags_q, flags_d;
  logic [15:0]      hold_q [NumLayerKeys];

  key_entry_t       e;
  logic             known;
  logic [SlotW-1:0] slot;
  logic [FlagW-1:0] abit, bbit, f;
  logic [15:0]      elapsed;
  logic             hold_we;
  logic [1:0]       n;
  res_t             r0, r1;

  always_comb begin
    e       = key_lookup(key_i);
    known   = key_i < 6'(NumKeys);
    slot    = e.a[SlotW-1:0];
    abit    = 10'(1) << e.a;
    bbit    = 10'(1) << e.b;
    elapsed = now_ms_i - hold_q[slot];
    f       = flags_q;
    hold_we = 1'b0;
    n       = 2'd0;
    r0      = '0;
    r1      = '0;

    if (known) begin
      if (e.kind == K_LAYER) begin
        if (pressed_i) begin
          hold_we = 1'b1;
          r0      = mk_layer(ACT_LAYER_ON, e.b[1:0]);
          n       = 2'd1;
        end else begin
          r0 = mk_layer(ACT_LAYER_OFF, e.b[1:0]);
          n  = 2'd1;
          if (elapsed < timeout_i) begin
            f  = '0;
            r1 = mk_tap(e.first);
            n  = 2'd2;
          end
        end
      end else if (pressed_i) begin
        case (e.kind)
          K_DBL: begin
            f = (f & abit) | ChoBit;
            if ((f & abit) != '0) begin
              r0 = mk_tap(HidBspc);
              r1 = mk_tap(e.second);
              n  = 2'd2;
              f  = f & ~abit;
            end else begin
              r0 = mk_tap(e.first);
              n  = 2'd1;
              f  = f | abit;
            end
          end
          K_INIT: begin
            f  = ChoBit;
            r0 = mk_tap(e.first);
            n  = 2'd1;
          end
          K_DUAL: begin
            f = f & ~DblMask & ~(JungMask & ~bbit);
            n = 2'd1;
            if (f[FCho]) begin
              f  = (f & ~ChoBit) | abit;
              r0 = mk_tap(e.first);
            end else begin
              f  = f | ChoBit;
              r0 = mk_tap(e.second);
            end
          end
          K_CMB: begin
            f = f & ~DblMask & ~(JungMask & ~abit);
            n = 2'd1;
            if (f[FCho]) begin
              f  = f & ~ChoBit;
              r0 = mk_tap(e.first);
            end else if ((f & abit) != '0) begin
              f  = f & ~abit;
              r0 = mk_tap(e.first);
            end else begin
              r0 = mk_tap(e.second);
            end
          end
          K_VOW: begin
            n = 2'd1;
            if (f[FCho]) begin
              r0 = mk_tap(e.first);
            end else begin
              r0 = mk_tap(e.second);
            end
            f = '0;
          end
          K_D: begin
            f = f & ~DblMask;
            n = 2'd1;
            if (f[FCho]) begin
              f  = f & ~(ChoBit | JungMask);
              r0 = mk_tap(e.first);
            end else if ((f & JungMask) != '0) begin
              f  = f & ~JungMask;
              r0 = mk_tap(e.first);
            end else begin
              r0 = mk_tap(e.second);
            end
          end
          default: begin
            f  = '0;
            r0 = mk_tap(e.first);
            n  = 2'd1;
          end
        endcase
      end
    end

    // mark the final result of this request
    if (n == 2'd1) r0.last = 1'b1;
    if (n == 2'd2) r1.last = 1'b1;

    flags_d = f;
    push_o.cnt = n;
    push_o.r0  = r0;
    push_o.r1  = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      for (int i = 0; i < NumLayerKeys; i++) hold_q[i] <= '0;
    end else if (acc_i) begin
      flags_q <= flags_d;
      if (hold_we) hold_q[slot] <= now_ms_i;
    end
  end

endmodule

### rtl/h3t2_outq.sv
// Two-entry result queue: the output register and the pending second tap.
module h3t2_outq import h3t2_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_valid_i,
  input  push_t push_i,
  input  logic  out_ready_i,
  output logic  out_valid_o,
  output res_t  out_res_o,
  output logic  in_ready_o
);

  logic [1:0] cnt_q;
  res_t       s0_q, s1_q;
  logic       pop;

  assign out_valid_o = cnt_q != 2'd0;
  assign out_res_o   = s0_q;
  assign pop         = out_valid_o && out_ready_i;
  // take a request only when the queue is empty or drains empty this cycle
  assign in_ready_o  = (cnt_q == 2'd0) || (cnt_q == 2'd1 && out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (push_valid_i) begin
      cnt_q <= push_i.cnt;
    end else if (pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_valid_i) begin
      s0_q <= push_i.r0;
      s1_q <= push_i.r1;
    end else if (pop) begin
      s0_q <= s1_q;
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3) else $error("result queue count out of range");

  a_follow_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !s0_q.last) |-> cnt_q == 2'd2)
    else $error("non-final result shown without its follower queued");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push_valid_i && cnt_q == 2'd2) |=> (s0_q == $past(s1_q) && s0_q.last))
    else $error("second result not advanced to output");

endmodule

### rtl/hangul_three_to_two_set_key_converter_core.sv
// Top level of the Hangul three-set to two-set key converter.
//
//  port         dir   handshake        carries
//  in_i         sink  valid/ready      key, pressed, now_ms
//  out_o        src   valid/ready      action, code, shift, layer, last
//  cfg_*_i      in    write enable     tap_timeout_ms
//
// The first result of a request appears in the output register the cycle after
// it is accepted. The single output register drains one result a cycle while
// out_o is ready; a request with two results holds off the next until both leave.
// Reset clears the compose flags and hold times and sets the timeout to 300.
// A stalled output holds its result; a new request is taken while the queue is
// empty or in the cycle the last queued result leaves.
module hangul_three_to_two_set_key_converter_core import h3t2_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  h3t2_in_if.sink     in_i,
  h3t2_out_if.source  out_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  logic [15:0] timeout_q;
  logic        acc;
  logic        in_ready;
  push_t       push;
  res_t        res;
  logic        out_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TapTimeoutRst;
    end else if (cfg_we_i) begin
      timeout_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = in_ready;
  assign acc        = in_i.valid && in_ready;

  h3t2_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (acc),
    .key_i     (in_i.key),
    .pressed_i (in_i.pressed),
    .now_ms_i  (in_i.now_ms),
    .timeout_i (timeout_q),
    .push_o    (push)
  );

  h3t2_outq u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (acc),
    .push_i       (push),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_valid),
    .out_res_o    (res),
    .in_ready_o   (in_ready)
  );

  assign out_o.valid  = out_valid;
  assign out_o.action = res.action;
  assign out_o.code   = res.code;
  assign out_o.shift  = res.shift;
  assign out_o.layer  = res.layer;
  assign out_o.last   = res.last;

endmodule
